// File: rtl/ssd_pkg.sv
// Shared widths, latencies and types of the segment distance pipeline.
package ssd_pkg;

   localparam int COORD_WIDTH = 24;
   localparam int SC_BITS     = 40;

   localparam int VEC_W  = COORD_WIDTH + 1;
   localparam int DOT_W  = 2 * VEC_W + 2;
   localparam int DET_W  = 2 * DOT_W + 2;
   localparam int P_W    = VEC_W + SC_BITS + 2;
   localparam int MUL_W  = (DOT_W > P_W) ? DOT_W : P_W;
   localparam int LIMB_W = 23;
   localparam int NLIMB  = (MUL_W + LIMB_W - 1) / LIMB_W;
   localparam int EXT_W  = NLIMB * LIMB_W;
   localparam int ROW_W  = LIMB_W * (NLIMB + 1);
   localparam int TOT_W  = 2 * EXT_W;
   localparam int PROD_W = 2 * MUL_W;
   localparam int SUM_W  = 2 * P_W;
   localparam int ROOT_W = P_W;
   localparam int FRAC_W = SC_BITS + 1;
   localparam int RND_W  = ROOT_W + 1;
   localparam int RES_W  = RND_W - SC_BITS;
   localparam int DIST_W = COORD_WIDTH + 1;

   localparam int MUL_LAT    = 3;
   localparam int DIV_STAGES = FRAC_W;
   localparam int SQRT_STAGES = ROOT_W;

   typedef logic signed [VEC_W-1:0]  coord_type;
   typedef logic signed [DOT_W-1:0]  dot_type;
   typedef logic signed [DET_W-1:0]  det_type;
   typedef logic signed [MUL_W-1:0]  mul_op_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [P_W-1:0]    pvec_type;

   typedef struct packed {
      coord_type [2:0] u;
      coord_type [2:0] v;
      coord_type [2:0] w;
   } geom_type;

   typedef struct packed {
      dot_type a;
      dot_type b;
      dot_type c;
      dot_type d;
      dot_type e;
   } dots_type;

endpackage

// File: rtl/ssd_if.sv
// Request and response channel interfaces of the segment distance unit.
interface ssd_req_if;
   logic valid;
   logic ready;
   logic signed [ssd_pkg::COORD_WIDTH-1:0] a_start_x;
   logic signed [ssd_pkg::COORD_WIDTH-1:0] a_start_y;
   logic signed [ssd_pkg::COORD_WIDTH-1:0] a_start_z;
   logic signed [ssd_pkg::COORD_WIDTH-1:0] a_end_x;
   logic signed [ssd_pkg::COORD_WIDTH-1:0] a_end_y;
   logic signed [ssd_pkg::COORD_WIDTH-1:0] a_end_z;
   logic signed [ssd_pkg::COORD_WIDTH-1:0] b_start_x;
   logic signed [ssd_pkg::COORD_WIDTH-1:0] b_start_y;
   logic signed [ssd_pkg::COORD_WIDTH-1:0] b_start_z;
   logic signed [ssd_pkg::COORD_WIDTH-1:0] b_end_x;
   logic signed [ssd_pkg::COORD_WIDTH-1:0] b_end_y;
   logic signed [ssd_pkg::COORD_WIDTH-1:0] b_end_z;

   modport source (
      output valid, a_start_x, a_start_y, a_start_z, a_end_x, a_end_y, a_end_z,
      output b_start_x, b_start_y, b_start_z, b_end_x, b_end_y, b_end_z,
      input  ready
   );
   modport sink (
      input  valid, a_start_x, a_start_y, a_start_z, a_end_x, a_end_y, a_end_z,
      input  b_start_x, b_start_y, b_start_z, b_end_x, b_end_y, b_end_z,
      output ready
   );
endinterface

interface ssd_rsp_if;
   logic valid;
   logic ready;
   logic [ssd_pkg::DIST_W-1:0] distance;

   modport source (output valid, distance, input ready);
   modport sink (input valid, distance, output ready);
endinterface

// File: rtl/ssd_mul.sv
// Three-stage signed multiplier built from narrow limb products.
module ssd_mul (
   input  logic                 clock,
   input  logic                 en,
   input  ssd_pkg::mul_op_type  a,
   input  ssd_pkg::mul_op_type  b,
   output ssd_pkg::prod_type    p
);
   logic [ssd_pkg::MUL_W-1:0] mag_a, mag_b;
   logic [ssd_pkg::EXT_W-1:0] ma, mb;
   logic [2*ssd_pkg::LIMB_W-1:0] pp_in [ssd_pkg::NLIMB][ssd_pkg::NLIMB];
   logic [2*ssd_pkg::LIMB_W-1:0] pp_ff [ssd_pkg::NLIMB][ssd_pkg::NLIMB];
   logic [ssd_pkg::ROW_W-1:0] row_in [ssd_pkg::NLIMB];
   logic [ssd_pkg::ROW_W-1:0] row_ff [ssd_pkg::NLIMB];
   logic [ssd_pkg::TOT_W-1:0] tot;
   logic sgn_in, sgn_ff, sgn2_ff;
   ssd_pkg::prod_type p_in, p_ff;

   // The product is formed on magnitudes; the sign is applied at the end.
   always_comb begin
      mag_a  = a[ssd_pkg::MUL_W-1] ? -a : a;
      mag_b  = b[ssd_pkg::MUL_W-1] ? -b : b;
      ma     = ssd_pkg::EXT_W'(mag_a);
      mb     = ssd_pkg::EXT_W'(mag_b);
      sgn_in = a[ssd_pkg::MUL_W-1] ^ b[ssd_pkg::MUL_W-1];
      for (int i = 0; i < ssd_pkg::NLIMB; i++) begin
         for (int j = 0; j < ssd_pkg::NLIMB; j++) begin
            pp_in[i][j] = ma[i*ssd_pkg::LIMB_W +: ssd_pkg::LIMB_W]
                        * mb[j*ssd_pkg::LIMB_W +: ssd_pkg::LIMB_W];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < ssd_pkg::NLIMB; i++) begin
         row_in[i] = '0;
         for (int j = 0; j < ssd_pkg::NLIMB; j++) begin
            row_in[i] = row_in[i]
                      + (ssd_pkg::ROW_W'(pp_ff[i][j]) << (j*ssd_pkg::LIMB_W));
         end
      end
   end

   always_comb begin
      tot = '0;
      for (int i = 0; i < ssd_pkg::NLIMB; i++) begin
         tot = tot + (ssd_pkg::TOT_W'(row_ff[i]) << (i*ssd_pkg::LIMB_W));
      end
      p_in = sgn2_ff ? -ssd_pkg::PROD_W'(tot) : ssd_pkg::PROD_W'(tot);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pp_ff   <= pp_in;
         sgn_ff  <= sgn_in;
         row_ff  <= row_in;
         sgn2_ff <= sgn_ff;
         p_ff    <= p_in;
      end
   end

   assign p = p_ff;

endmodule

// File: rtl/ssd_div.sv
// Pipelined restoring divider for the two clamped line parameters.
module ssd_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_vld,
   input  ssd_pkg::geom_type                 in_geom,
   input  logic [1:0][ssd_pkg::DET_W-1:0]    num,
   input  logic [1:0][ssd_pkg::DET_W-1:0]    den,
   output logic                              out_vld,
   output ssd_pkg::geom_type                 out_geom,
   output logic [1:0][ssd_pkg::FRAC_W-1:0]   quo
);
   localparam int LAST = ssd_pkg::DIV_STAGES - 1;

   logic [ssd_pkg::DIV_STAGES-1:0] vld_ff;
   ssd_pkg::geom_type geom_ff [ssd_pkg::DIV_STAGES];

   logic [ssd_pkg::DET_W:0]    rem_src [ssd_pkg::DIV_STAGES][2];
   logic [ssd_pkg::DET_W:0]    rem_in  [ssd_pkg::DIV_STAGES][2];
   logic [ssd_pkg::DET_W:0]    rem_ff  [ssd_pkg::DIV_STAGES][2];
   logic [ssd_pkg::DET_W-1:0]  den_src [ssd_pkg::DIV_STAGES][2];
   logic [ssd_pkg::DET_W-1:0]  den_ff  [ssd_pkg::DIV_STAGES][2];
   logic [ssd_pkg::FRAC_W-1:0] q_src   [ssd_pkg::DIV_STAGES][2];
   logic [ssd_pkg::FRAC_W-1:0] q_in    [ssd_pkg::DIV_STAGES][2];
   logic [ssd_pkg::FRAC_W-1:0] q_ff    [ssd_pkg::DIV_STAGES][2];
   logic                       nz_src  [ssd_pkg::DIV_STAGES][2];
   logic                       nz_ff   [ssd_pkg::DIV_STAGES][2];

   // The first stage compares the numerator as it is; every later stage
   // doubles the partial remainder and retires one quotient bit.
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         rem_src[0][l] = {1'b0, num[l]};
         den_src[0][l] = den[l];
         q_src[0][l]   = '0;
         nz_src[0][l]  = |num[l];
      end
      for (int s = 1; s < ssd_pkg::DIV_STAGES; s++) begin
         for (int l = 0; l < 2; l++) begin
            rem_src[s][l] = {rem_ff[s-1][l][ssd_pkg::DET_W-1:0], 1'b0};
            den_src[s][l] = den_ff[s-1][l];
            q_src[s][l]   = {q_ff[s-1][l][ssd_pkg::FRAC_W-2:0], 1'b0};
            nz_src[s][l]  = nz_ff[s-1][l];
         end
      end
      for (int s = 0; s < ssd_pkg::DIV_STAGES; s++) begin
         for (int l = 0; l < 2; l++) begin
            if (rem_src[s][l] >= {1'b0, den_src[s][l]}) begin
               rem_in[s][l] = rem_src[s][l] - {1'b0, den_src[s][l]};
               q_in[s][l]   = q_src[s][l] | ssd_pkg::FRAC_W'(1);
            end else begin
               rem_in[s][l] = rem_src[s][l];
               q_in[s][l]   = q_src[s][l];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[ssd_pkg::DIV_STAGES-2:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         geom_ff[0] <= in_geom;
         for (int s = 1; s < ssd_pkg::DIV_STAGES; s++) begin
            geom_ff[s] <= geom_ff[s-1];
         end
         for (int s = 0; s < ssd_pkg::DIV_STAGES; s++) begin
            for (int l = 0; l < 2; l++) begin
               rem_ff[s][l] <= rem_in[s][l];
               den_ff[s][l] <= den_src[s][l];
               q_ff[s][l]   <= q_in[s][l];
               nz_ff[s][l]  <= nz_src[s][l];
            end
         end
      end
   end

   // A zero numerator (which also covers a zero denominator) gives zero.
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         quo[l] = nz_ff[LAST][l] ? q_ff[LAST][l] : '0;
      end
   end

   assign out_vld  = vld_ff[LAST];
   assign out_geom = geom_ff[LAST];

endmodule

// File: rtl/ssd_sqrt.sv
// Pipelined digit-by-digit integer square root, one root bit per stage.
module ssd_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_vld,
   input  logic [ssd_pkg::SUM_W-1:0]  x,
   output logic                       out_vld,
   output logic [ssd_pkg::ROOT_W-1:0] root
);
   localparam int RW   = ssd_pkg::SUM_W + 2;
   localparam int LAST = ssd_pkg::SQRT_STAGES - 1;

   logic [ssd_pkg::SQRT_STAGES-1:0] vld_ff;
   logic [RW-1:0]             rem_src [ssd_pkg::SQRT_STAGES];
   logic [RW-1:0]             rem_in  [ssd_pkg::SQRT_STAGES];
   logic [RW-1:0]             rem_ff  [ssd_pkg::SQRT_STAGES];
   logic [RW-1:0]             trial   [ssd_pkg::SQRT_STAGES];
   logic [ssd_pkg::ROOT_W-1:0] r_src  [ssd_pkg::SQRT_STAGES];
   logic [ssd_pkg::ROOT_W-1:0] r_in   [ssd_pkg::SQRT_STAGES];
   logic [ssd_pkg::ROOT_W-1:0] r_ff   [ssd_pkg::SQRT_STAGES];

   // Stage s decides root bit k = ROOT_W-1-s. The remainder holds x - r*r,
   // and setting bit k costs (2r + 2^k) * 2^k.
   always_comb begin
      rem_src[0] = RW'(x);
      r_src[0]   = '0;
      for (int s = 1; s < ssd_pkg::SQRT_STAGES; s++) begin
         rem_src[s] = rem_ff[s-1];
         r_src[s]   = r_ff[s-1];
      end
      for (int s = 0; s < ssd_pkg::SQRT_STAGES; s++) begin
         trial[s] = ((RW'(r_src[s]) << 1) | (RW'(1) << (ssd_pkg::ROOT_W-1-s)))
                    << (ssd_pkg::ROOT_W-1-s);
         if (rem_src[s] >= trial[s]) begin
            rem_in[s] = rem_src[s] - trial[s];
            r_in[s]   = r_src[s] | (ssd_pkg::ROOT_W'(1) << (ssd_pkg::ROOT_W-1-s));
         end else begin
            rem_in[s] = rem_src[s];
            r_in[s]   = r_src[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[ssd_pkg::SQRT_STAGES-2:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         r_ff   <= r_in;
      end
   end

   assign out_vld = vld_ff[LAST];
   assign root    = r_ff[LAST];

endmodule

// File: rtl/segment_segment_distance_unit.sv
// Throughput: one request word per cycle, except while the pipeline holds; the depth
// is set by the two 41-stage parameter dividers and the 67-stage square root pipeline.
// The whole pipeline holds while a finished response word waits.
// Reset clears all valid bits; the data path registers are not reset.
module segment_segment_distance_unit (
   input  logic      clock,
   input  logic      reset,
   ssd_req_if.sink   req_chan,
   ssd_rsp_if.source rsp_chan
);
   logic en;

   // Stage 1: direction and offset vectors.
   ssd_pkg::coord_type a_st [3], a_en [3], b_st [3], b_en [3];
   ssd_pkg::geom_type geom1_in, geom1_ff;
   logic vld1_ff;

   // Stage 2: component products.
   logic signed [2*ssd_pkg::VEC_W-1:0] prod2_in [5][3];
   logic signed [2*ssd_pkg::VEC_W-1:0] prod2_ff [5][3];
   ssd_pkg::geom_type geom2_ff;
   logic vld2_ff;

   // Stage 3: dot products.
   ssd_pkg::dots_type dots3_in, dots3_ff;
   ssd_pkg::geom_type geom3_ff;
   logic vld3_ff;

   // Stages 4 to 6: products of dot products.
   ssd_pkg::prod_type ac, bb, be, cd, ae, bd;
   logic [ssd_pkg::MUL_LAT-1:0] vldm_ff;
   ssd_pkg::geom_type geomm_ff [ssd_pkg::MUL_LAT];
   ssd_pkg::dots_type dotsm_ff [ssd_pkg::MUL_LAT];

   // Stage 7: determinant and raw numerators.
   ssd_pkg::det_type det7_in, sn7_in, tn7_in, det7_ff, sn7_ff, tn7_ff;
   ssd_pkg::dots_type dots7_ff;
   ssd_pkg::geom_type geom7_ff;
   logic vld7_ff;

   // Stage 8: clamp of the first segment's parameter.
   ssd_pkg::det_type sn8_in, sd8_in, tn8_in, td8_in;
   ssd_pkg::det_type sn8_ff, sd8_ff, tn8_ff, td8_ff;
   ssd_pkg::dots_type dots8_ff;
   ssd_pkg::geom_type geom8_ff;
   logic vld8_ff;

   // Stage 9: clamp of the second segment's parameter with edge recompute.
   ssd_pkg::det_type sn9_in, sd9_in, tn9_in, td9_in;
   ssd_pkg::det_type sn9_ff, sd9_ff, tn9_ff, td9_ff;
   ssd_pkg::det_type m_lo, m_hi;
   ssd_pkg::geom_type geom9_ff;
   logic vld9_ff;

   // Divider outputs.
   logic div_vld;
   ssd_pkg::geom_type div_geom;
   logic [1:0][ssd_pkg::FRAC_W-1:0] quo;

   // Scaling products.
   ssd_pkg::prod_type su [3], tv [3];
   logic [ssd_pkg::MUL_LAT-1:0] vldq_ff;
   ssd_pkg::geom_type geomq_ff [ssd_pkg::MUL_LAT];

   // Difference vector, squares and their sum.
   ssd_pkg::pvec_type p_in [3], p_ff [3];
   logic vldp_ff;
   ssd_pkg::prod_type sq [3];
   logic [ssd_pkg::MUL_LAT-1:0] vlds_ff;
   logic [ssd_pkg::SUM_W-1:0] sum_in, sum_ff;
   logic vldsum_ff;

   // Root, rounding and output register.
   logic sqrt_vld;
   logic [ssd_pkg::ROOT_W-1:0] root;
   logic [ssd_pkg::RND_W-1:0] rnd;
   logic [ssd_pkg::RES_W-1:0] res;
   logic [ssd_pkg::DIST_W-1:0] dist_in, dist_ff;
   logic rsp_vld_ff;

   // Every stage moves together; nothing moves while the response is held.
   assign en             = !rsp_vld_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   always_comb begin
      a_st[0] = ssd_pkg::coord_type'(req_chan.a_start_x);
      a_st[1] = ssd_pkg::coord_type'(req_chan.a_start_y);
      a_st[2] = ssd_pkg::coord_type'(req_chan.a_start_z);
      a_en[0] = ssd_pkg::coord_type'(req_chan.a_end_x);
      a_en[1] = ssd_pkg::coord_type'(req_chan.a_end_y);
      a_en[2] = ssd_pkg::coord_type'(req_chan.a_end_z);
      b_st[0] = ssd_pkg::coord_type'(req_chan.b_start_x);
      b_st[1] = ssd_pkg::coord_type'(req_chan.b_start_y);
      b_st[2] = ssd_pkg::coord_type'(req_chan.b_start_z);
      b_en[0] = ssd_pkg::coord_type'(req_chan.b_end_x);
      b_en[1] = ssd_pkg::coord_type'(req_chan.b_end_y);
      b_en[2] = ssd_pkg::coord_type'(req_chan.b_end_z);
      for (int i = 0; i < 3; i++) begin
         geom1_in.u[i] = a_en[i] - a_st[i];
         geom1_in.v[i] = b_en[i] - b_st[i];
         geom1_in.w[i] = a_st[i] - b_st[i];
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prod2_in[0][i] = $signed(geom1_ff.u[i]) * $signed(geom1_ff.u[i]);
         prod2_in[1][i] = $signed(geom1_ff.u[i]) * $signed(geom1_ff.v[i]);
         prod2_in[2][i] = $signed(geom1_ff.v[i]) * $signed(geom1_ff.v[i]);
         prod2_in[3][i] = $signed(geom1_ff.u[i]) * $signed(geom1_ff.w[i]);
         prod2_in[4][i] = $signed(geom1_ff.v[i]) * $signed(geom1_ff.w[i]);
      end
   end

   always_comb begin
      dots3_in.a = ssd_pkg::DOT_W'(prod2_ff[0][0]) + ssd_pkg::DOT_W'(prod2_ff[0][1])
                 + ssd_pkg::DOT_W'(prod2_ff[0][2]);
      dots3_in.b = ssd_pkg::DOT_W'(prod2_ff[1][0]) + ssd_pkg::DOT_W'(prod2_ff[1][1])
                 + ssd_pkg::DOT_W'(prod2_ff[1][2]);
      dots3_in.c = ssd_pkg::DOT_W'(prod2_ff[2][0]) + ssd_pkg::DOT_W'(prod2_ff[2][1])
                 + ssd_pkg::DOT_W'(prod2_ff[2][2]);
      dots3_in.d = ssd_pkg::DOT_W'(prod2_ff[3][0]) + ssd_pkg::DOT_W'(prod2_ff[3][1])
                 + ssd_pkg::DOT_W'(prod2_ff[3][2]);
      dots3_in.e = ssd_pkg::DOT_W'(prod2_ff[4][0]) + ssd_pkg::DOT_W'(prod2_ff[4][1])
                 + ssd_pkg::DOT_W'(prod2_ff[4][2]);
   end

   ssd_mul u_mul_ac (.clock(clock), .en(en),
      .a(ssd_pkg::mul_op_type'($signed(dots3_ff.a))),
      .b(ssd_pkg::mul_op_type'($signed(dots3_ff.c))), .p(ac));
   ssd_mul u_mul_bb (.clock(clock), .en(en),
      .a(ssd_pkg::mul_op_type'($signed(dots3_ff.b))),
      .b(ssd_pkg::mul_op_type'($signed(dots3_ff.b))), .p(bb));
   ssd_mul u_mul_be (.clock(clock), .en(en),
      .a(ssd_pkg::mul_op_type'($signed(dots3_ff.b))),
      .b(ssd_pkg::mul_op_type'($signed(dots3_ff.e))), .p(be));
   ssd_mul u_mul_cd (.clock(clock), .en(en),
      .a(ssd_pkg::mul_op_type'($signed(dots3_ff.c))),
      .b(ssd_pkg::mul_op_type'($signed(dots3_ff.d))), .p(cd));
   ssd_mul u_mul_ae (.clock(clock), .en(en),
      .a(ssd_pkg::mul_op_type'($signed(dots3_ff.a))),
      .b(ssd_pkg::mul_op_type'($signed(dots3_ff.e))), .p(ae));
   ssd_mul u_mul_bd (.clock(clock), .en(en),
      .a(ssd_pkg::mul_op_type'($signed(dots3_ff.b))),
      .b(ssd_pkg::mul_op_type'($signed(dots3_ff.d))), .p(bd));

   always_comb begin
      det7_in = ssd_pkg::det_type'(ac) - ssd_pkg::det_type'(bb);
      sn7_in  = ssd_pkg::det_type'(be) - ssd_pkg::det_type'(cd);
      tn7_in  = ssd_pkg::det_type'(ae) - ssd_pkg::det_type'(bd);
   end

   // A zero determinant means parallel lines: the first segment's start
   // is taken and only the second parameter is solved.
   always_comb begin
      if (det7_ff == '0) begin
         sn8_in = '0;
         sd8_in = ssd_pkg::DET_W'(1);
         tn8_in = ssd_pkg::det_type'($signed(dots7_ff.e));
         td8_in = ssd_pkg::det_type'($signed(dots7_ff.c));
      end else begin
         sd8_in = det7_ff;
         td8_in = det7_ff;
         sn8_in = sn7_ff;
         tn8_in = tn7_ff;
         if (sn7_ff < 0) begin
            sn8_in = '0;
            tn8_in = ssd_pkg::det_type'($signed(dots7_ff.e));
            td8_in = ssd_pkg::det_type'($signed(dots7_ff.c));
         end else if (det7_ff < sn7_ff) begin
            sn8_in = det7_ff;
            tn8_in = ssd_pkg::det_type'($signed(dots7_ff.e))
                   + ssd_pkg::det_type'($signed(dots7_ff.b));
            td8_in = ssd_pkg::det_type'($signed(dots7_ff.c));
         end
      end
   end

   // When the second parameter leaves its range, the first one is
   // recomputed against the matching end of the second segment.
   always_comb begin
      m_lo   = -ssd_pkg::det_type'($signed(dots8_ff.d));
      m_hi   = ssd_pkg::det_type'($signed(dots8_ff.b))
             - ssd_pkg::det_type'($signed(dots8_ff.d));
      sn9_in = sn8_ff;
      sd9_in = sd8_ff;
      tn9_in = tn8_ff;
      td9_in = td8_ff;
      if (tn8_ff < 0) begin
         tn9_in = '0;
         if (m_lo < 0) begin
            sn9_in = '0;
         end else if (ssd_pkg::det_type'($signed(dots8_ff.a)) < m_lo) begin
            sn9_in = sd8_ff;
         end else begin
            sn9_in = m_lo;
            sd9_in = ssd_pkg::det_type'($signed(dots8_ff.a));
         end
      end else if (td8_ff < tn8_ff) begin
         tn9_in = td8_ff;
         if (m_hi < 0) begin
            sn9_in = '0;
         end else if (ssd_pkg::det_type'($signed(dots8_ff.a)) < m_hi) begin
            sn9_in = sd8_ff;
         end else begin
            sn9_in = m_hi;
            sd9_in = ssd_pkg::det_type'($signed(dots8_ff.a));
         end
      end
   end

   ssd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (vld9_ff),
      .in_geom  (geom9_ff),
      .num      ({$unsigned(tn9_ff), $unsigned(sn9_ff)}),
      .den      ({$unsigned(td9_ff), $unsigned(sd9_ff)}),
      .out_vld  (div_vld),
      .out_geom (div_geom),
      .quo      (quo)
   );

   for (genvar i = 0; i < 3; i++) begin : g_scale
      ssd_mul u_mul_su (.clock(clock), .en(en),
         .a(ssd_pkg::MUL_W'(quo[0])),
         .b(ssd_pkg::mul_op_type'($signed(div_geom.u[i]))), .p(su[i]));
      ssd_mul u_mul_tv (.clock(clock), .en(en),
         .a(ssd_pkg::MUL_W'(quo[1])),
         .b(ssd_pkg::mul_op_type'($signed(div_geom.v[i]))), .p(tv[i]));
      ssd_mul u_mul_sq (.clock(clock), .en(en),
         .a(ssd_pkg::mul_op_type'(p_ff[i])),
         .b(ssd_pkg::mul_op_type'(p_ff[i])), .p(sq[i]));
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p_in[i] = (ssd_pkg::pvec_type'($signed(geomq_ff[ssd_pkg::MUL_LAT-1].w[i]))
                    <<< ssd_pkg::SC_BITS)
                 + ssd_pkg::pvec_type'(su[i]) - ssd_pkg::pvec_type'(tv[i]);
      end
      sum_in = ssd_pkg::SUM_W'($unsigned(sq[0])) + ssd_pkg::SUM_W'($unsigned(sq[1]))
             + ssd_pkg::SUM_W'($unsigned(sq[2]));
   end

   ssd_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (vldsum_ff),
      .x       (sum_ff),
      .out_vld (sqrt_vld),
      .root    (root)
   );

   // Round half up to an integer distance and saturate.
   always_comb begin
      rnd     = ssd_pkg::RND_W'(root) + (ssd_pkg::RND_W'(1) << (ssd_pkg::SC_BITS - 1));
      res     = rnd[ssd_pkg::RND_W-1:ssd_pkg::SC_BITS];
      dist_in = (|res[ssd_pkg::RES_W-1:ssd_pkg::DIST_W]) ? '1 : res[ssd_pkg::DIST_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff    <= 1'b0;
         vld2_ff    <= 1'b0;
         vld3_ff    <= 1'b0;
         vldm_ff    <= '0;
         vld7_ff    <= 1'b0;
         vld8_ff    <= 1'b0;
         vld9_ff    <= 1'b0;
         vldq_ff    <= '0;
         vldp_ff    <= 1'b0;
         vlds_ff    <= '0;
         vldsum_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         vld1_ff    <= req_chan.valid;
         vld2_ff    <= vld1_ff;
         vld3_ff    <= vld2_ff;
         vldm_ff    <= {vldm_ff[ssd_pkg::MUL_LAT-2:0], vld3_ff};
         vld7_ff    <= vldm_ff[ssd_pkg::MUL_LAT-1];
         vld8_ff    <= vld7_ff;
         vld9_ff    <= vld8_ff;
         vldq_ff    <= {vldq_ff[ssd_pkg::MUL_LAT-2:0], div_vld};
         vldp_ff    <= vldq_ff[ssd_pkg::MUL_LAT-1];
         vlds_ff    <= {vlds_ff[ssd_pkg::MUL_LAT-2:0], vldp_ff};
         vldsum_ff  <= vlds_ff[ssd_pkg::MUL_LAT-1];
         rsp_vld_ff <= sqrt_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         geom1_ff    <= geom1_in;
         prod2_ff    <= prod2_in;
         geom2_ff    <= geom1_ff;
         dots3_ff    <= dots3_in;
         geom3_ff    <= geom2_ff;
         geomm_ff[0] <= geom3_ff;
         dotsm_ff[0] <= dots3_ff;
         for (int k = 1; k < ssd_pkg::MUL_LAT; k++) begin
            geomm_ff[k] <= geomm_ff[k-1];
            dotsm_ff[k] <= dotsm_ff[k-1];
         end
         det7_ff  <= det7_in;
         sn7_ff   <= sn7_in;
         tn7_ff   <= tn7_in;
         dots7_ff <= dotsm_ff[ssd_pkg::MUL_LAT-1];
         geom7_ff <= geomm_ff[ssd_pkg::MUL_LAT-1];
         sn8_ff   <= sn8_in;
         sd8_ff   <= sd8_in;
         tn8_ff   <= tn8_in;
         td8_ff   <= td8_in;
         dots8_ff <= dots7_ff;
         geom8_ff <= geom7_ff;
         sn9_ff   <= sn9_in;
         sd9_ff   <= sd9_in;
         tn9_ff   <= tn9_in;
         td9_ff   <= td9_in;
         geom9_ff <= geom8_ff;
         geomq_ff[0] <= div_geom;
         for (int k = 1; k < ssd_pkg::MUL_LAT; k++) begin
            geomq_ff[k] <= geomq_ff[k-1];
         end
         p_ff    <= p_in;
         sum_ff  <= sum_in;
         dist_ff <= dist_in;
      end
   end

   assign rsp_chan.valid    = rsp_vld_ff;
   assign rsp_chan.distance = dist_ff;

endmodule

// File: tb/sv/segment_segment_distance_unit_tb.sv
// Testbench for the segment distance unit: random and directed segment pairs against a predictor.
`timescale 1ns / 100ps

module segment_segment_distance_unit_tb;

   localparam int CW = ssd_pkg::COORD_WIDTH;
   localparam logic [63:0] DIST_MAX = 64'd33554431;
   localparam int DRAIN_CYCLES = 300;

   typedef logic signed [255:0] wide_type;
   typedef logic [11:0][CW-1:0] seg_pair_type;

   logic clock;
   logic reset;
   ssd_req_if req_chan ();
   ssd_rsp_if rsp_chan ();

   segment_segment_distance_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   seg_pair_type                     pending_pairs[$];
   logic [ssd_pkg::DIST_W-1:0]       expected_distances[$];
   int                               error_count = 0;
   int                               burst_left = 0;
   int                               gap_left = 0;
   int                               stall_mode = 0;
   int                               stall_left = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic wide_type widen(logic [CW-1:0] x);
      return wide_type'(signed'(x));
   endfunction

   function automatic wide_type clamp_param(wide_type m, wide_type a, wide_type s_den_in,
                                            output wide_type s_den);
      s_den = s_den_in;
      if (m < 0) return 0;
      if (a < m) return s_den_in;
      s_den = a;
      return m;
   endfunction

   function automatic logic [63:0] fraction_of(wide_type num, wide_type den);
      logic [255:0] q;
      if (num == 0 || den == 0) return 64'd0;
      q = (256'(num) << ssd_pkg::SC_BITS) / 256'(den);
      return q[63:0];
   endfunction

   // Exact closest distance, rounded half up to the output grid and saturated.
   function automatic logic [ssd_pkg::DIST_W-1:0] segment_distance(seg_pair_type s);
      wide_type u[3], v[3], w[3];
      wide_type a, b, c, d, e, det, s_num, s_den, t_num, t_den, p, sum, root, trial;
      logic [63:0] sc, tc;
      logic [255:0] res;
      a = 0; b = 0; c = 0; d = 0; e = 0; sum = 0; root = 0;
      for (int i = 0; i < 3; i++) begin
         u[i] = widen(s[3+i]) - widen(s[i]);
         v[i] = widen(s[9+i]) - widen(s[6+i]);
         w[i] = widen(s[i]) - widen(s[6+i]);
      end
      for (int i = 0; i < 3; i++) begin
         a += u[i] * u[i];
         b += u[i] * v[i];
         c += v[i] * v[i];
         d += u[i] * w[i];
         e += v[i] * w[i];
      end
      det = a * c - b * b;
      if (det == 0) begin
         s_num = 0; s_den = 1; t_num = e; t_den = c;
      end else begin
         s_den = det; t_den = det;
         s_num = b * e - c * d;
         t_num = a * e - b * d;
         if (s_num < 0) begin
            s_num = 0; t_num = e; t_den = c;
         end else if (s_den < s_num) begin
            s_num = s_den; t_num = e + b; t_den = c;
         end
      end
      if (t_num < 0) begin
         t_num = 0;
         s_num = clamp_param(-d, a, s_den, s_den);
      end else if (t_den < t_num) begin
         t_num = t_den;
         s_num = clamp_param(b - d, a, s_den, s_den);
      end
      sc = fraction_of(s_num, s_den);
      tc = fraction_of(t_num, t_den);
      for (int i = 0; i < 3; i++) begin
         p = (w[i] <<< ssd_pkg::SC_BITS) + wide_type'({1'b0, sc}) * u[i]
           - wide_type'({1'b0, tc}) * v[i];
         sum += p * p;
      end
      for (int bit_idx = 95; bit_idx >= 0; bit_idx--) begin
         trial = root | (wide_type'(1) <<< bit_idx);
         if (trial * trial <= sum) root = trial;
      end
      res = 256'(root + (wide_type'(1) <<< (ssd_pkg::SC_BITS - 1))) >> ssd_pkg::SC_BITS;
      if (res > 256'(DIST_MAX)) res = 256'(DIST_MAX);
      return res[ssd_pkg::DIST_W-1:0];
   endfunction

   function automatic logic [CW-1:0] rand_coord(int kind);
      case (kind)
         0: return CW'($urandom);
         1: return CW'($urandom_range(0, 4000)) - CW'(2000);
         2: return $urandom_range(0, 1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
         default: return CW'($urandom_range(0, 200000)) - CW'(100000);
      endcase
   endfunction

   function automatic seg_pair_type random_pair();
      seg_pair_type s;
      int kind, shape;
      kind = $urandom_range(0, 3);
      shape = $urandom_range(0, 9);
      for (int i = 0; i < 12; i++) s[i] = rand_coord(($urandom_range(0, 7) == 0) ? 0 : kind);
      if (shape == 0) begin
         // Second segment is a shifted copy of the first: parallel.
         for (int i = 0; i < 3; i++) s[9+i] = s[6+i] + (s[3+i] - s[i]);
      end else if (shape == 1) begin
         for (int i = 0; i < 3; i++) s[3+i] = s[i];
      end else if (shape == 2) begin
         for (int i = 0; i < 3; i++) s[9+i] = s[6+i];
      end else if (shape == 3) begin
         // Collinear: B lies on the line of A, at twice and minus three times A's direction.
         for (int i = 0; i < 3; i++) begin
            s[i] = CW'($urandom_range(0, 2000)) - CW'(1000);
            s[3+i] = s[i] + CW'($urandom_range(0, 60)) - CW'(30);
            s[6+i] = s[i] + CW'(2) * (s[3+i] - s[i]);
            s[9+i] = s[i] - CW'(3) * (s[3+i] - s[i]);
         end
      end
      return s;
   endfunction

   // Driver: a new word is offered once the previous one has been taken.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         {req_chan.b_end_z, req_chan.b_end_y, req_chan.b_end_x,
          req_chan.b_start_z, req_chan.b_start_y, req_chan.b_start_x,
          req_chan.a_end_z, req_chan.a_end_y, req_chan.a_end_x,
          req_chan.a_start_z, req_chan.a_start_y, req_chan.a_start_x} <= '0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (gap_left > 0 || pending_pairs.size() == 0) begin
            if (gap_left > 0) gap_left <= gap_left - 1;
            req_chan.valid <= 1'b0;
         end else begin
            seg_pair_type s;
            s = pending_pairs.pop_front();
            expected_distances.push_back(segment_distance(s));
            req_chan.valid <= 1'b1;
            {req_chan.b_end_z, req_chan.b_end_y, req_chan.b_end_x,
             req_chan.b_start_z, req_chan.b_start_y, req_chan.b_start_x,
             req_chan.a_end_z, req_chan.a_end_y, req_chan.a_end_x,
             req_chan.a_start_z, req_chan.a_start_y, req_chan.a_start_x} <= s;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   // Monitor: checks each accepted distance word; the ready pattern switches between free flow, random and sparse.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(20, 200);
         end else begin
            stall_left <= stall_left - 1;
         end
         case (stall_mode)
            0: rsp_chan.ready <= 1'b1;
            1: rsp_chan.ready <= 1'($urandom_range(0, 1));
            default: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
         endcase
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_distances.size() == 0) begin
               $display("%0t: unexpected distance word: expected none, actual %0d",
                        $time, rsp_chan.distance);
               error_count++;
            end else begin
               logic [ssd_pkg::DIST_W-1:0] want;
               want = expected_distances.pop_front();
               if (rsp_chan.distance !== want) begin
                  $display("%0t: distance mismatch: expected %0d, actual %0d",
                           $time, want, rsp_chan.distance);
                  error_count++;
               end
            end
         end
      end
   end

   task automatic wait_drained();
      while (pending_pairs.size() != 0 || expected_distances.size() != 0 || req_chan.valid)
         @(posedge clock);
   endtask

   initial begin
      seg_pair_type s;
      logic [CW-1:0] max_c, min_c;
      max_c = {1'b0, {(CW-1){1'b1}}};
      min_c = {1'b1, {(CW-1){1'b0}}};
      reset = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed words: extremes, degenerate and parallel segments, clamped ends.
      pending_pairs.push_back('0);
      for (int i = 0; i < 12; i++) s[i] = max_c;
      pending_pairs.push_back(s);
      for (int i = 0; i < 12; i++) s[i] = min_c;
      pending_pairs.push_back(s);
      for (int i = 0; i < 12; i++) s[i] = (i < 6) ? min_c : max_c;
      pending_pairs.push_back(s);
      for (int i = 0; i < 12; i++) s[i] = (i % 6 < 3) ? min_c : max_c;
      pending_pairs.push_back(s);
      for (int i = 0; i < 12; i++) s[i] = ((i / 3) % 3 == 0) ? max_c : min_c;
      pending_pairs.push_back(s);
      for (int i = 0; i < 12; i++) s[i] = (i % 2) ? max_c : min_c;
      pending_pairs.push_back(s);
      for (int i = 0; i < 12; i++) s[i] = (i % 2) ? min_c : max_c;
      pending_pairs.push_back(s);
      // Crossing segments along x and y at the origin.
      s = '0; s[0] = CW'(-256); s[3] = CW'(256); s[7] = CW'(-256); s[10] = CW'(256);
      pending_pairs.push_back(s);
      // Skew segments 256 apart in z.
      s[8] = CW'(256); s[11] = CW'(256);
      pending_pairs.push_back(s);
      // Parallel segments, offset and overlapping.
      s = '0; s[3] = CW'(1024); s[6] = CW'(512); s[7] = CW'(300);
      s[9] = CW'(1536); s[10] = CW'(300);
      pending_pairs.push_back(s);
      // Parallel with no overlap, and antiparallel.
      s = '0; s[3] = CW'(1024); s[6] = CW'(4096); s[7] = CW'(77);
      s[9] = CW'(8192); s[10] = CW'(77);
      pending_pairs.push_back(s);
      s[6] = CW'(8192); s[9] = CW'(4096);
      pending_pairs.push_back(s);
      // Both segments points; one segment a point.
      s = '0; s[0] = CW'(100); s[1] = CW'(-7); s[6] = CW'(-300); s[11] = CW'(5);
      for (int i = 0; i < 3; i++) begin s[3+i] = s[i]; s[9+i] = s[6+i]; end
      pending_pairs.push_back(s);
      s[9] = CW'(999); s[10] = CW'(-999);
      pending_pairs.push_back(s);
      // Closest points off both ends of each segment.
      s = '0; s[3] = CW'(256); s[6] = CW'(1000); s[7] = CW'(-5000);
      s[9] = CW'(1000); s[10] = CW'(-4000);
      pending_pairs.push_back(s);
      s = '0; s[3] = CW'(256); s[6] = CW'(-1000); s[7] = CW'(4000);
      s[9] = CW'(-1000); s[10] = CW'(5000);
      pending_pairs.push_back(s);
      // Widest separation: every coordinate of A at the minimum and of B at the maximum.
      s = '0;
      for (int i = 0; i < 6; i++) s[i] = min_c;
      for (int i = 6; i < 12; i++) s[i] = max_c;
      pending_pairs.push_back(s);
      wait_drained();

      for (int chunk = 0; chunk < 5; chunk++) begin
         for (int n = 0; n < 150; n++) pending_pairs.push_back(random_pair());
         if (chunk == 2) wait_drained();
         else while (pending_pairs.size() != 0) @(posedge clock);
      end
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #4ms;
      $display("TEST FAILED");
      $finish;
   end

endmodule
